FILE: rtl/core/sdtt_pkg.sv
// Package with the types, codes and defaults of the sorted deadline timer table.
package sdtt_pkg;

   localparam int NUM_TIMERS_DEFAULT = 16;

   localparam int MODE_W  = 2;
   localparam int ID_W    = 4;
   localparam int DATA_W  = 32;
   localparam int STAT_W  = 2;

   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REARM  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd3;

   localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_NO_SLOT = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_BAD     = 2'd2;

   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_EXPIRED = 1'b1;

   typedef enum logic [1:0] {
      SLOT_FREE    = 2'd0,
      SLOT_PENDING = 2'd1,
      SLOT_EXPIRED = 2'd2
   } slot_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_TICK_INC,
      ST_CHECK,
      ST_ADD_SEARCH,
      ST_FIND,
      ST_REMOVE,
      ST_ARM,
      ST_REBASE,
      ST_INSERT,
      ST_RESPOND
   } state_type;

endpackage

FILE: rtl/core/sdtt_req_if.sv
// Request channel interface: valid, ready and one command item.
interface sdtt_req_if;
   logic                        valid;
   logic                        ready;
   logic [sdtt_pkg::MODE_W-1:0] mode;
   logic [sdtt_pkg::ID_W-1:0]   timer_id;
   logic [sdtt_pkg::DATA_W-1:0] delay;

   modport source (output valid, output mode, output timer_id, output delay, input ready);
   modport sink (input valid, input mode, input timer_id, input delay, output ready);
endinterface

FILE: rtl/core/sdtt_rsp_if.sv
// Response channel interface: valid, ready and one result item.
interface sdtt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        event_kind;
   logic [sdtt_pkg::STAT_W-1:0] status;
   logic [sdtt_pkg::ID_W-1:0]   result_id;
   logic [sdtt_pkg::DATA_W-1:0] now_count;
   logic                        last;

   modport source (output valid, output event_kind, output status, output result_id,
                   output now_count, output last, input ready);
   modport sink (input valid, input event_kind, input status, input result_id,
                 input now_count, input last, output ready);
endinterface

FILE: rtl/core/sorted_deadline_timer_table_core.sv
// Sorted deadline timer table: one-shot timers kept in a deadline-ordered list.
//
// Commands enter on req_if (tick, add, re-arm, delete) and results leave on
// rsp_if, one transfer per result; the last result of a command has last set.
// A tick reports each expiring timer in deadline order, or one acknowledge.
// The block takes one command at a time and is ready only while idle.
// Deadline sums and compares go through one 33-bit add/subtract unit under
// the sequencer, and the sorted list moves one entry per cycle, so a command
// takes longer the more timers are pending: tick with nothing due and delete
// are the shortest, a re-arm with deadline overflow the longest. An add also
// searches up to NUM_TIMERS slots, and a tick takes expiring timers one by one.
// Results sit in an output register: a new command is taken while a result
// still waits, and the sequencer holds when it has a result to give and the
// receiver stalls. Reset clears the count, frees all slots and empties the
// list; no clearing pass is needed.
module sorted_deadline_timer_table_core #(
   parameter int NUM_TIMERS = sdtt_pkg::NUM_TIMERS_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   sdtt_req_if.sink     req_if,
   sdtt_rsp_if.source   rsp_if
);

   localparam int IDXW = $clog2(NUM_TIMERS);
   localparam int CW   = $clog2(NUM_TIMERS + 1);
   localparam int DW   = sdtt_pkg::DATA_W;

   sdtt_pkg::state_type state_ff, state_in;

   logic [DW-1:0]                count_ff, count_in;
   logic [sdtt_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic [sdtt_pkg::ID_W-1:0]    id_ff, id_in;
   logic [DW-1:0]                delay_ff, delay_in;
   logic [DW-1:0]                key_ff, key_in;
   logic [IDXW-1:0]              slot_ff, slot_in;
   logic [IDXW-1:0]              ptr_ff, ptr_in;
   logic [CW-1:0]                pend_cnt_ff, pend_cnt_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic [CW-1:0]                p_ff, p_in;
   logic [CW-1:0]                k_ff, k_in;
   logic                         hold_valid_ff, hold_valid_in;
   logic [IDXW-1:0]              hold_slot_ff, hold_slot_in;
   logic [sdtt_pkg::STAT_W-1:0]  resp_status_ff, resp_status_in;
   logic [sdtt_pkg::ID_W-1:0]    resp_id_ff, resp_id_in;

   sdtt_pkg::slot_state_type     sst_ff [NUM_TIMERS];
   sdtt_pkg::slot_state_type     sst_in [NUM_TIMERS];
   logic [IDXW-1:0]              list_slot_ff [NUM_TIMERS];
   logic [IDXW-1:0]              list_slot_in [NUM_TIMERS];
   logic [DW-1:0]                list_dl_ff [NUM_TIMERS];
   logic [DW-1:0]                list_dl_in [NUM_TIMERS];

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_kind_ff, rsp_kind_in;
   logic [sdtt_pkg::STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [sdtt_pkg::ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [DW-1:0]                rsp_now_ff, rsp_now_in;
   logic                         rsp_last_ff, rsp_last_in;

   // Shared add/subtract unit.
   logic [DW-1:0]  alu_a, alu_b;
   logic           alu_sub;
   logic [DW:0]    alu_res;
   logic           alu_ge, alu_eq, alu_gt;

   logic [CW-1:0]   rd_cnt;
   logic [IDXW-1:0] rd_idx;
   logic [IDXW-1:0] rd_slot;
   logic [DW-1:0]   rd_dl;
   logic [IDXW-1:0] slot_next;
   logic            id_ok;
   logic            out_free;
   logic            req_take;
   logic            expires;
   logic            move_up;
   sdtt_pkg::slot_state_type cur_sst;

   assign req_take  = req_if.valid && req_if.ready;
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign id_ok     = ({28'd0, id_ff} < 32'(NUM_TIMERS));
   assign slot_next = (slot_ff == IDXW'(NUM_TIMERS - 1)) ? '0 : slot_ff + IDXW'(1);
   assign cur_sst   = sst_ff[slot_ff];

   // Indexed read port into the sorted list; the head is also read directly.
   always_comb begin
      case (state_ff)
         sdtt_pkg::ST_REMOVE: rd_cnt = idx_ff + CW'(1);
         sdtt_pkg::ST_INSERT: rd_cnt = idx_ff - CW'(1);
         default:             rd_cnt = idx_ff;
      endcase
   end
   assign rd_idx  = rd_cnt[IDXW-1:0];
   assign rd_slot = list_slot_ff[rd_idx];
   assign rd_dl   = list_dl_ff[rd_idx];

   always_comb begin
      alu_sub = 1'b1;
      alu_a   = count_ff;
      alu_b   = list_dl_ff[0];
      case (state_ff)
         sdtt_pkg::ST_TICK_INC: begin
            alu_sub = 1'b0;
            alu_b   = DW'(1);
         end
         sdtt_pkg::ST_ARM: begin
            alu_sub = 1'b0;
            alu_b   = delay_ff;
         end
         sdtt_pkg::ST_REBASE: begin
            alu_a = rd_dl;
            alu_b = count_ff;
         end
         sdtt_pkg::ST_INSERT: begin
            alu_a = rd_dl;
            alu_b = key_ff;
         end
         default: begin
            alu_a = count_ff;
            alu_b = list_dl_ff[0];
         end
      endcase
   end

   // For subtraction bit DW of the result is set when a >= b.
   assign alu_res = {1'b0, alu_a} + (alu_sub ? {1'b0, ~alu_b} : {1'b0, alu_b})
                    + (DW+1)'(alu_sub);
   assign alu_ge  = alu_res[DW];
   assign alu_eq  = (alu_res[DW-1:0] == '0);
   assign alu_gt  = alu_ge && !alu_eq;

   assign expires = (pend_cnt_ff != '0) && alu_ge;
   // An equal deadline that stood after the moved timer goes behind it.
   assign move_up = (idx_ff != '0) &&
                    (alu_gt || (alu_eq && ((idx_ff - CW'(1)) >= p_ff)));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sdtt_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_if.mode == sdtt_pkg::MODE_TICK) begin
                  state_in = sdtt_pkg::ST_TICK_INC;
               end else begin
                  state_in = sdtt_pkg::ST_DISPATCH;
               end
            end
         end
         sdtt_pkg::ST_DISPATCH: begin
            if (mode_ff == sdtt_pkg::MODE_ADD) begin
               state_in = sdtt_pkg::ST_ADD_SEARCH;
            end else if (id_ok && mode_ff == sdtt_pkg::MODE_REARM &&
                         cur_sst == sdtt_pkg::SLOT_PENDING) begin
               state_in = sdtt_pkg::ST_FIND;
            end else if (id_ok && mode_ff == sdtt_pkg::MODE_REARM &&
                         cur_sst == sdtt_pkg::SLOT_EXPIRED) begin
               state_in = sdtt_pkg::ST_ARM;
            end else begin
               state_in = sdtt_pkg::ST_RESPOND;
            end
         end
         sdtt_pkg::ST_TICK_INC: state_in = sdtt_pkg::ST_CHECK;
         sdtt_pkg::ST_CHECK: begin
            if (out_free && !expires) begin
               state_in = sdtt_pkg::ST_IDLE;
            end
         end
         sdtt_pkg::ST_ADD_SEARCH: begin
            if (cur_sst == sdtt_pkg::SLOT_FREE) begin
               state_in = sdtt_pkg::ST_ARM;
            end else if (k_ff == CW'(NUM_TIMERS - 1)) begin
               state_in = sdtt_pkg::ST_RESPOND;
            end
         end
         sdtt_pkg::ST_FIND: begin
            if (rd_slot == slot_ff) begin
               state_in = sdtt_pkg::ST_REMOVE;
            end
         end
         sdtt_pkg::ST_REMOVE: begin
            if (!((idx_ff + CW'(1)) < pend_cnt_ff)) begin
               state_in = sdtt_pkg::ST_ARM;
            end
         end
         sdtt_pkg::ST_ARM: begin
            if (alu_res[DW]) begin
               state_in = sdtt_pkg::ST_REBASE;
            end else begin
               state_in = sdtt_pkg::ST_INSERT;
            end
         end
         sdtt_pkg::ST_REBASE: begin
            if (!(idx_ff < pend_cnt_ff)) begin
               state_in = sdtt_pkg::ST_INSERT;
            end
         end
         sdtt_pkg::ST_INSERT: begin
            if (!move_up) begin
               state_in = sdtt_pkg::ST_RESPOND;
            end
         end
         sdtt_pkg::ST_RESPOND: begin
            if (out_free) begin
               state_in = sdtt_pkg::ST_IDLE;
            end
         end
         default: state_in = sdtt_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      count_in       = count_ff;
      mode_in        = mode_ff;
      id_in          = id_ff;
      delay_in       = delay_ff;
      key_in         = key_ff;
      slot_in        = slot_ff;
      ptr_in         = ptr_ff;
      pend_cnt_in    = pend_cnt_ff;
      idx_in         = idx_ff;
      p_in           = p_ff;
      k_in           = k_ff;
      hold_valid_in  = hold_valid_ff;
      hold_slot_in   = hold_slot_ff;
      resp_status_in = resp_status_ff;
      resp_id_in     = resp_id_ff;
      sst_in         = sst_ff;
      list_slot_in   = list_slot_ff;
      list_dl_in     = list_dl_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_now_in     = rsp_now_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         sdtt_pkg::ST_IDLE: begin
            if (req_take) begin
               mode_in        = req_if.mode;
               id_in          = req_if.timer_id;
               delay_in       = req_if.delay;
               resp_status_in = sdtt_pkg::STATUS_OK;
               resp_id_in     = '0;
               hold_valid_in  = 1'b0;
               k_in           = '0;
               if (req_if.mode == sdtt_pkg::MODE_ADD) begin
                  slot_in = ptr_ff;
               end else begin
                  slot_in = IDXW'(req_if.timer_id);
               end
            end
         end
         sdtt_pkg::ST_DISPATCH: begin
            idx_in = '0;
            p_in   = pend_cnt_ff;
            if (mode_ff != sdtt_pkg::MODE_ADD) begin
               if (!id_ok) begin
                  resp_status_in = sdtt_pkg::STATUS_BAD;
               end else if (mode_ff == sdtt_pkg::MODE_DELETE) begin
                  if (cur_sst == sdtt_pkg::SLOT_EXPIRED) begin
                     sst_in[slot_ff] = sdtt_pkg::SLOT_FREE;
                  end else begin
                     resp_status_in = sdtt_pkg::STATUS_BAD;
                  end
               end else if (cur_sst == sdtt_pkg::SLOT_FREE) begin
                  resp_status_in = sdtt_pkg::STATUS_BAD;
               end
            end
         end
         sdtt_pkg::ST_TICK_INC: begin
            count_in = alu_res[DW-1:0];
         end
         sdtt_pkg::ST_CHECK: begin
            if (out_free) begin
               if (expires) begin
                  if (hold_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = sdtt_pkg::KIND_EXPIRED;
                     rsp_status_in = sdtt_pkg::STATUS_OK;
                     rsp_id_in     = sdtt_pkg::ID_W'(hold_slot_ff);
                     rsp_now_in    = count_ff;
                     rsp_last_in   = 1'b0;
                  end
                  hold_valid_in = 1'b1;
                  hold_slot_in  = list_slot_ff[0];
                  sst_in[list_slot_ff[0]] = sdtt_pkg::SLOT_EXPIRED;
                  for (int i = 0; i < NUM_TIMERS - 1; i++) begin
                     list_slot_in[i] = list_slot_ff[i+1];
                     list_dl_in[i]   = list_dl_ff[i+1];
                  end
                  pend_cnt_in = pend_cnt_ff - CW'(1);
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = sdtt_pkg::STATUS_OK;
                  rsp_now_in    = count_ff;
                  rsp_last_in   = 1'b1;
                  if (hold_valid_ff) begin
                     rsp_kind_in = sdtt_pkg::KIND_EXPIRED;
                     rsp_id_in   = sdtt_pkg::ID_W'(hold_slot_ff);
                  end else begin
                     rsp_kind_in = sdtt_pkg::KIND_ACK;
                     rsp_id_in   = '0;
                  end
               end
            end
         end
         sdtt_pkg::ST_ADD_SEARCH: begin
            if (cur_sst == sdtt_pkg::SLOT_FREE) begin
               p_in = pend_cnt_ff;
            end else if (k_ff == CW'(NUM_TIMERS - 1)) begin
               resp_status_in = sdtt_pkg::STATUS_NO_SLOT;
            end else begin
               k_in    = k_ff + CW'(1);
               slot_in = slot_next;
            end
         end
         sdtt_pkg::ST_FIND: begin
            if (rd_slot == slot_ff) begin
               p_in = idx_ff;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         sdtt_pkg::ST_REMOVE: begin
            // Close the gap left by the timer that is being moved.
            if ((idx_ff + CW'(1)) < pend_cnt_ff) begin
               list_slot_in[idx_ff[IDXW-1:0]] = rd_slot;
               list_dl_in[idx_ff[IDXW-1:0]]   = rd_dl;
               idx_in = idx_ff + CW'(1);
            end else begin
               pend_cnt_in = pend_cnt_ff - CW'(1);
            end
         end
         sdtt_pkg::ST_ARM: begin
            key_in = alu_res[DW-1:0];
            idx_in = alu_res[DW] ? '0 : pend_cnt_ff;
         end
         sdtt_pkg::ST_REBASE: begin
            if (idx_ff < pend_cnt_ff) begin
               list_dl_in[idx_ff[IDXW-1:0]] = alu_res[DW-1:0];
               idx_in = idx_ff + CW'(1);
            end else begin
               count_in = '0;
               key_in   = delay_ff;
               idx_in   = pend_cnt_ff;
            end
         end
         sdtt_pkg::ST_INSERT: begin
            if (move_up) begin
               list_slot_in[idx_ff[IDXW-1:0]] = rd_slot;
               list_dl_in[idx_ff[IDXW-1:0]]   = rd_dl;
               idx_in = idx_ff - CW'(1);
            end else begin
               list_slot_in[idx_ff[IDXW-1:0]] = slot_ff;
               list_dl_in[idx_ff[IDXW-1:0]]   = key_ff;
               pend_cnt_in     = pend_cnt_ff + CW'(1);
               sst_in[slot_ff] = sdtt_pkg::SLOT_PENDING;
               if (mode_ff == sdtt_pkg::MODE_ADD) begin
                  ptr_in     = slot_next;
                  resp_id_in = sdtt_pkg::ID_W'(slot_ff);
               end
            end
         end
         sdtt_pkg::ST_RESPOND: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = sdtt_pkg::KIND_ACK;
               rsp_status_in = resp_status_ff;
               rsp_id_in     = resp_id_ff;
               rsp_now_in    = count_ff;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sdtt_pkg::ST_IDLE;
         count_ff      <= '0;
         ptr_ff        <= '0;
         pend_cnt_ff   <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            sst_ff[i] <= sdtt_pkg::SLOT_FREE;
         end
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ptr_ff        <= ptr_in;
         pend_cnt_ff   <= pend_cnt_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         sst_ff        <= sst_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      id_ff          <= id_in;
      delay_ff       <= delay_in;
      key_ff         <= key_in;
      slot_ff        <= slot_in;
      idx_ff         <= idx_in;
      p_ff           <= p_in;
      k_ff           <= k_in;
      hold_slot_ff   <= hold_slot_in;
      resp_status_ff <= resp_status_in;
      resp_id_ff     <= resp_id_in;
      list_slot_ff   <= list_slot_in;
      list_dl_ff     <= list_dl_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_now_ff     <= rsp_now_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_if.ready      = (state_ff == sdtt_pkg::ST_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.event_kind = rsp_kind_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.result_id  = rsp_id_ff;
   assign rsp_if.now_count  = rsp_now_ff;
   assign rsp_if.last       = rsp_last_ff;

   logic [NUM_TIMERS-1:0] pend_bits;
   always_comb begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
         pend_bits[i] = (sst_ff[i] == sdtt_pkg::SLOT_PENDING);
      end
   end

`ifndef SYNTHESIS
   // While idle the list length matches the number of pending slots.
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdtt_pkg::ST_IDLE) |-> ($countones(pend_bits) == 32'(pend_cnt_ff)))
      else $error("pending list length differs from pending slot count");

   // While idle, the list head never holds a later deadline than its successor.
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdtt_pkg::ST_IDLE && pend_cnt_ff >= CW'(2)) |->
      (list_dl_ff[0] <= list_dl_ff[1]))
      else $error("pending list head out of order");

   // An expiry report always carries status ok.
   a_expiry_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == sdtt_pkg::KIND_EXPIRED) |->
      (rsp_status_ff == sdtt_pkg::STATUS_OK))
      else $error("expiry report with error status");

   // A result is loaded only after a command was taken.
   a_no_idle_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdtt_pkg::ST_IDLE && !req_take) |=> !$rose(rsp_valid_ff))
      else $error("result produced with no command in progress");
`endif

endmodule

FILE: test/sdtt_tb_pkg.sv
// Package with the scoreboard that predicts and checks timer table results.
package sdtt_tb_pkg;
   import sdtt_pkg::*;

   localparam int NT = NUM_TIMERS_DEFAULT;

   typedef struct packed {
      logic                event_kind;
      logic [STAT_W-1:0]   status;
      logic [ID_W-1:0]     result_id;
      logic [DATA_W-1:0]   now_count;
      logic                last;
   } timer_event_type;

   class timer_scoreboard;
      logic [DATA_W-1:0] count;
      logic [DATA_W-1:0] due [NT];
      slot_state_type    slot [NT];
      logic [ID_W-1:0]   order [NT];
      int                n_pending;
      int                hunt_ptr;
      timer_event_type   expected_events [$];
      int                errors;

      function new();
         count = '0;
         n_pending = 0;
         hunt_ptr = 0;
         errors = 0;
         foreach (slot[i]) begin
            slot[i] = SLOT_FREE;
            due[i] = '0;
            order[i] = '0;
         end
      endfunction

      function void push_event(logic kind, logic [STAT_W-1:0] st, logic [ID_W-1:0] id,
                               logic fin);
         timer_event_type e;
         e.event_kind = kind;
         e.status = st;
         e.result_id = id;
         e.now_count = count;
         e.last = fin;
         expected_events.push_back(e);
      endfunction

      // Stable insertion sort of the pending list by deadline.
      function void resort();
         int j;
         logic [ID_W-1:0] v;
         for (int i = 1; i < n_pending; i++) begin
            v = order[i];
            j = i;
            while (j > 0 && due[order[j-1]] > due[v]) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = v;
         end
      endfunction

      // On overflow the count is taken off every pending deadline and cleared.
      function void set_deadline(int s, logic [DATA_W-1:0] dly);
         logic [DATA_W:0] sum;
         sum = {1'b0, count} + {1'b0, dly};
         if (sum[DATA_W]) begin
            for (int i = 0; i < n_pending; i++) due[order[i]] -= count;
            count = '0;
            due[s] = dly;
         end else begin
            due[s] = sum[DATA_W-1:0];
         end
      endfunction

      function void note_command(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                                 logic [DATA_W-1:0] dly);
         int n;
         int s;
         case (mode)
            MODE_TICK: begin
               count++;
               n = 0;
               while (n < n_pending && due[order[n]] <= count) n++;
               if (n == 0) begin
                  push_event(KIND_ACK, STATUS_OK, '0, 1'b1);
               end else begin
                  for (int i = 0; i < n; i++) begin
                     slot[order[i]] = SLOT_EXPIRED;
                     push_event(KIND_EXPIRED, STATUS_OK, order[i], i == n - 1);
                  end
                  for (int i = n; i < n_pending; i++) order[i-n] = order[i];
                  n_pending -= n;
               end
            end
            MODE_ADD: begin
               s = -1;
               for (int k = 0; k < NT && s < 0; k++)
                  if (slot[(hunt_ptr + k) % NT] == SLOT_FREE) s = (hunt_ptr + k) % NT;
               if (s < 0) begin
                  push_event(KIND_ACK, STATUS_NO_SLOT, '0, 1'b1);
               end else begin
                  set_deadline(s, dly);
                  slot[s] = SLOT_PENDING;
                  order[n_pending++] = ID_W'(s);
                  resort();
                  hunt_ptr = (s + 1) % NT;
                  push_event(KIND_ACK, STATUS_OK, ID_W'(s), 1'b1);
               end
            end
            MODE_REARM: begin
               if (slot[id] == SLOT_FREE) begin
                  push_event(KIND_ACK, STATUS_BAD, '0, 1'b1);
               end else begin
                  set_deadline(int'(id), dly);
                  if (slot[id] == SLOT_EXPIRED) begin
                     slot[id] = SLOT_PENDING;
                     order[n_pending++] = id;
                  end
                  resort();
                  push_event(KIND_ACK, STATUS_OK, '0, 1'b1);
               end
            end
            default: begin
               if (slot[id] == SLOT_EXPIRED) begin
                  slot[id] = SLOT_FREE;
                  push_event(KIND_ACK, STATUS_OK, '0, 1'b1);
               end else begin
                  push_event(KIND_ACK, STATUS_BAD, '0, 1'b1);
               end
            end
         endcase
      endfunction

      task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
         $display("mismatch %s: got %0h, expected %0h", what, got, want);
         errors++;
      endtask

      task check_event(timer_event_type got);
         timer_event_type want;
         if (expected_events.size() == 0) begin
            report("unexpected result transfer", DATA_W'(got.result_id), '0);
            return;
         end
         want = expected_events.pop_front();
         if (got.event_kind !== want.event_kind)
            report("event_kind", DATA_W'(got.event_kind), DATA_W'(want.event_kind));
         if (got.status !== want.status)
            report("status", DATA_W'(got.status), DATA_W'(want.status));
         if (got.result_id !== want.result_id)
            report("result_id", DATA_W'(got.result_id), DATA_W'(want.result_id));
         if (got.now_count !== want.now_count)
            report("now_count", got.now_count, want.now_count);
         if (got.last !== want.last)
            report("last", DATA_W'(got.last), DATA_W'(want.last));
      endtask
   endclass
endpackage

FILE: test/tb_sorted_deadline_timer_table_core.sv
// Testbench top: drives timer commands and checks every result transfer.
module tb_sorted_deadline_timer_table_core;
   import sdtt_pkg::*;
   import sdtt_tb_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic quiet = 1'b0;
   int   idle_cycles = 0;

   sdtt_req_if req();
   sdtt_rsp_if rsp();

   timer_scoreboard board = new();

   sorted_deadline_timer_table_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req.sink),
      .rsp_if (rsp.source)
   );

   always #2 clock = ~clock;

   // Receiver: random stall bursts until the quiet part of the run.
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp.ready <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
         rsp.ready <= 1'b1;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         board.check_event({rsp.event_kind, rsp.status, rsp.result_id, rsp.now_count,
                            rsp.last});
      if (!reset && (rsp.valid && rsp.ready || req.valid && req.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Valid stays high after a transfer until the next send or drain decides.
   task automatic send(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id, logic [DATA_W-1:0] dly);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.mode <= mode;
      req.timer_id <= id;
      req.delay <= dly;
      do @(posedge clock); while (!(req.valid && req.ready));
      board.note_command(mode, id, dly);
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      do @(negedge clock); while (board.expected_events.size() != 0);
   endtask

   // Mostly short delays so timers really expire; sometimes wide values.
   function automatic logic [DATA_W-1:0] pick_delay();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom_range(0, 6);
      endcase
   endfunction

   initial begin
      logic [MODE_W-1:0] m;
      req.valid = 1'b0;
      req.mode = MODE_TICK;
      req.timer_id = '0;
      req.delay = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Directed part.
      send(MODE_TICK, 4'd0, 32'd0);
      send(MODE_REARM, 4'd15, 32'd5);
      send(MODE_DELETE, 4'd0, 32'd0);
      send(MODE_ADD, 4'd9, 32'd0);
      send(MODE_ADD, 4'd0, 32'd2);
      send(MODE_ADD, 4'd0, 32'd2);
      send(MODE_ADD, 4'd0, 32'd1);
      send(MODE_TICK, 4'd0, 32'd0);
      send(MODE_TICK, 4'd0, 32'd0);
      send(MODE_DELETE, 4'd1, 32'd0);
      send(MODE_DELETE, 4'd3, 32'd0);
      send(MODE_REARM, 4'd2, 32'd3);
      send(MODE_REARM, 4'd1, 32'd1);
      send(MODE_ADD, 4'd0, 32'hFFFF_FFFF);
      send(MODE_ADD, 4'd0, 32'hFFFF_FFFE);
      send(MODE_TICK, 4'd0, 32'd0);
      send(MODE_REARM, 4'd4, 32'hFFFF_FFFF);
      drain();
      for (int i = 0; i < 16; i++) send(MODE_ADD, 4'hF, 32'h8000_0000);
      send(MODE_ADD, 4'd0, 32'd0);
      drain();
      for (int i = 0; i < 16; i++) send(MODE_REARM, i[3:0], 32'd4);
      repeat (4) send(MODE_TICK, 4'd0, 32'd0);
      for (int i = 0; i < 16; i++) send(MODE_DELETE, i[3:0], 32'd0);
      // Random part; pending list is empty here, so count wrap cannot fire by ticks.
      for (int i = 0; i < 240; i++) begin
         if (i == 190) begin
            drain();
            quiet = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: m = MODE_TICK;
            4, 5, 6: m = MODE_ADD;
            7: m = MODE_REARM;
            default: m = MODE_DELETE;
         endcase
         send(m, ID_W'($urandom_range(0, 15)), pick_delay());
      end
      drain();
      repeat (100) @(negedge clock);
      if (board.errors == 0 && board.expected_events.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
